// ===== src/ffba_pkg.sv =====
package ffba_pkg;

  localparam int unsigned HeapUnitsDefault = 1024;
  localparam int unsigned LimitW = 11;
  localparam int unsigned ReqW = 16;
  localparam int unsigned OffW = 15;
  // units needed for the largest request: (8 + 65535 + 15) / 16
  localparam int unsigned NeedW = 13;
  localparam logic [LimitW-1:0] LimitReset = 11'd1024;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [ReqW-1:0] request_size;
    logic [OffW-1:0] release_offset;
  } in_item_t;

  typedef struct packed {
    logic [OffW-1:0] payload_offset;
    logic            granted;
  } out_item_t;

endpackage

// ===== src/ffba_hdr_mem.sv =====
module ffba_hdr_mem #(
  parameter int unsigned Depth = ffba_pkg::HeapUnitsDefault,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned DataW = $clog2(Depth + 1) + 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/first_fit_block_allocator.sv =====
// Allocate: first-fit walk of the block headers, a header write for the rest
//   of a split block, or heap growth; free: header read and write. One item
//   at a time; the walk rate is one header per cycle, set by the single,
//   registered read port of the header memory. Reset: heap end cleared to an
//   empty heap, limit register to 1024 units; the header memory is uncleared,
//   so the user ensures headers are written before being read; unchecked here.
module first_fit_block_allocator #(
  parameter int unsigned HEAP_UNITS = ffba_pkg::HeapUnitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffba_pkg::LimitW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ffba_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ffba_pkg::out_item_t           out_data_o
);

  import ffba_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_UNITS);
  localparam int unsigned SW = $clog2(HEAP_UNITS + 1);
  localparam int unsigned DW = SW + 1;
  localparam int unsigned CW = ((SW > NeedW) ? SW : NeedW) + 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFree  = 3'd1;
  localparam logic [2:0] StWalk  = 3'd2;
  localparam logic [2:0] StSplit = 3'd3;
  localparam logic [2:0] StGrow  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [LimitW-1:0] limit_q, limit_d;
  logic [SW-1:0]     heap_end_q, heap_end_d;
  logic [CW-1:0]     u_q, u_d;
  logic [CW-1:0]     need_q, need_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              ok_q, ok_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  logic [ReqW:0] need_sum;
  logic [CW-1:0] need_new;
  logic [CW-1:0] free_unit;
  logic [CW-1:0] he_ext;
  logic [CW-1:0] eff_limit;
  logic [CW-1:0] blk_size;
  logic [CW-1:0] next_u;
  logic [CW-1:0] grow_end;
  logic [CW-1:0] res_unit1;

  ffba_hdr_mem #(
    .Depth (HEAP_UNITS),
    .AddrW (AW),
    .DataW (DW)
  ) u_hdr_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign need_sum  = {1'b0, in_data_i.request_size} + (ReqW + 1)'(23);
  assign need_new  = CW'(need_sum[ReqW:4]);
  assign free_unit = CW'(in_data_i.release_offset[OffW-1:4]) - CW'(1);
  assign he_ext    = CW'(heap_end_q);
  assign eff_limit = (CW'(limit_q) > CW'(HEAP_UNITS)) ? CW'(HEAP_UNITS) : CW'(limit_q);
  assign blk_size  = CW'(mem_rdata[DW-1:1]);
  assign next_u    = u_q + blk_size;
  assign grow_end  = he_ext + need_q;
  assign res_unit1 = u_q + CW'(1);

  always_comb begin
    state_d     = state_q;
    limit_d     = limit_q;
    heap_end_d  = heap_end_q;
    u_d         = u_q;
    need_d      = need_q;
    rem_d       = rem_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = u_q[AW-1:0];
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (cfg_valid_i) begin
      limit_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_data_i.kind == KindFree) begin
            if ((in_data_i.release_offset != '0) && (in_data_i.release_offset[3:0] == 4'd0)
                && (free_unit < he_ext)) begin
              mem_re    = 1'b1;
              mem_raddr = free_unit[AW-1:0];
              u_d       = free_unit;
              state_d   = StFree;
            end
          end else if (in_data_i.request_size == '0) begin
            ok_d    = 1'b0;
            state_d = StDone;
          end else begin
            need_d = need_new;
            u_d    = '0;
            if (heap_end_q == '0) begin
              state_d = StGrow;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = StWalk;
            end
          end
        end
      end
      StFree: begin
        mem_we    = 1'b1;
        mem_wdata = {mem_rdata[DW-1:1], 1'b0};
        state_d   = StIdle;
      end
      StWalk: begin
        if (!mem_rdata[0] && (blk_size >= need_q)) begin
          mem_we = 1'b1;
          ok_d   = 1'b1;
          if (blk_size >= need_q + CW'(2)) begin
            mem_wdata = {need_q[SW-1:0], 1'b1};
            rem_d     = blk_size - need_q;
            state_d   = StSplit;
          end else begin
            mem_wdata = {mem_rdata[DW-1:1], 1'b1};
            state_d   = StDone;
          end
        end else if ((blk_size == '0) || (next_u >= he_ext)) begin
          state_d = StGrow;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = next_u[AW-1:0];
          u_d       = next_u;
        end
      end
      StSplit: begin
        mem_we    = 1'b1;
        mem_waddr = grow_end[AW-1:0] - he_ext[AW-1:0] + u_q[AW-1:0];
        mem_wdata = {rem_q[SW-1:0], 1'b0};
        state_d   = StDone;
      end
      StGrow: begin
        if (grow_end > eff_limit) begin
          ok_d = 1'b0;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = heap_end_q[AW-1:0];
          mem_wdata  = {need_q[SW-1:0], 1'b1};
          u_d        = he_ext;
          heap_end_d = grow_end[SW-1:0];
          ok_d       = 1'b1;
        end
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.granted        = ok_q;
          out_d.payload_offset = ok_q ? {res_unit1[10:0], 4'd0} : '0;
          state_d              = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      limit_q     <= LimitReset;
      heap_end_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      heap_end_q  <= heap_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    need_q <= need_d;
    rem_q  <= rem_d;
    ok_q   <= ok_d;
    out_q  <= out_d;
  end

endmodule

// ===== src/ffba_checker.sv =====
module ffba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ffba_pkg::out_item_t out_data_o
);

  import ffba_pkg::*;

  // a waiting result item stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.granted |-> out_data_o.payload_offset == '0)
    else $error("failed allocation with nonzero offset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |->
      (out_data_o.payload_offset[3:0] == 4'd0) && (out_data_o.payload_offset != '0))
    else $error("granted offset not a unit payload start");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== dv/tb_first_fit_block_allocator.sv =====
`timescale 1ns / 100ps

module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  localparam int unsigned HeapUnits = HeapUnitsDefault;
  localparam int unsigned PhaseItems = 170;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  in_item_t         in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;

  // heap image: per unit, {size, allocated}; written marks block starts
  logic [11:0]      hdr_mem [HeapUnits];
  bit               hdr_written [HeapUnits];
  int unsigned      heap_end_u = 0;
  int unsigned      limit_u = LimitReset;

  out_item_t        result_q [$];
  int unsigned      n_errors = 0;
  int unsigned      results_seen = 0;
  int unsigned      grants_seen = 0;
  int unsigned      useful_items = 0;
  int unsigned      limits_set = 0;
  bit               steady = 1'b0;
  bit               hold_done = 1'b0;
  int unsigned      hold_left = 0;

  // directed items; typed rows carry an expectation read straight off the rules
  dir_row_t dir_rows [21] = '{
    '{'{KindAlloc, 16'd0,     15'd0},     1'b1, '{15'd0,  1'b0}},
    '{'{KindFree,  16'd0,     15'd0},     1'b0, '{15'd0,  1'b0}},
    '{'{KindAlloc, 16'd1,     15'd0},     1'b1, '{15'd16, 1'b1}},
    '{'{KindAlloc, 16'd8,     15'd0},     1'b1, '{15'd32, 1'b1}},
    '{'{KindAlloc, 16'd9,     15'd0},     1'b1, '{15'd48, 1'b1}},
    '{'{KindAlloc, 16'hFFFF,  15'd0},     1'b1, '{15'd0,  1'b0}},
    '{'{KindFree,  16'd0,     15'd48},    1'b0, '{15'd0,  1'b0}},
    '{'{KindAlloc, 16'd1,     15'd0},     1'b0, '{15'd0,  1'b0}},
    '{'{KindAlloc, 16'd40,    15'd0},     1'b0, '{15'd0,  1'b0}},
    '{'{KindAlloc, 16'd100,   15'd0},     1'b0, '{15'd0,  1'b0}},
    '{'{KindFree,  16'd0,     15'd128},   1'b0, '{15'd0,  1'b0}},
    '{'{KindAlloc, 16'd20,    15'd0},     1'b0, '{15'd0,  1'b0}},
    '{'{KindFree,  16'd0,     15'd7},     1'b0, '{15'd0,  1'b0}},
    '{'{KindFree,  16'd0,     15'd8},     1'b0, '{15'd0,  1'b0}},
    '{'{KindFree,  16'd0,     15'd16384}, 1'b0, '{15'd0,  1'b0}},
    '{'{KindFree,  16'd0,     15'd16368}, 1'b0, '{15'd0,  1'b0}},
    '{'{KindAlloc, 16'd60,    15'd0},     1'b0, '{15'd0,  1'b0}},
    '{'{KindFree,  16'd0,     15'd16},    1'b0, '{15'd0,  1'b0}},
    '{'{KindAlloc, 16'd8,     15'd0},     1'b0, '{15'd0,  1'b0}},
    '{'{KindAlloc, 16'd16360, 15'd0},     1'b0, '{15'd0,  1'b0}},
    '{'{KindAlloc, 16'd16,    15'd0},     1'b0, '{15'd0,  1'b0}}
  };

  first_fit_block_allocator #(
    .HEAP_UNITS(HeapUnits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void store_hdr(int unsigned unit, int unsigned size, bit used);
    if (unit < HeapUnits) begin
      hdr_mem[unit] = 12'((size << 1) | used);
      hdr_written[unit] = 1'b1;
    end
  endfunction

  // Applies one item to the heap image; returns 1 when the item yields a result.
  function automatic bit alloc_outcome(input in_item_t it, output out_item_t res,
                                       output bit counted);
    int unsigned need;
    int unsigned unit;
    int unsigned pos;
    int unsigned steps;
    int unsigned size;
    int unsigned old;
    int unsigned eff;
    res = '0;
    counted = 1'b0;
    if (it.kind == KindFree) begin
      if (it.release_offset == '0 || it.release_offset[3:0] != 4'd0) return 1'b0;
      unit = 32'(it.release_offset) / 16 - 1;
      if (unit >= heap_end_u) return 1'b0;
      hdr_mem[unit][0] = 1'b0;
      counted = 1'b1;
      return 1'b0;
    end
    counted = 1'b1;
    if (it.request_size == '0) return 1'b1;
    need = (32'd8 + 32'(it.request_size) + 32'd15) / 32'd16;
    unit = heap_end_u;
    pos = 0;
    steps = 0;
    while (pos < heap_end_u && steps < HeapUnits) begin
      size = 32'(hdr_mem[pos][11:1]);
      if (!hdr_mem[pos][0] && size >= need) begin
        unit = pos;
        break;
      end
      if (size == 0) break;
      pos += size;
      steps++;
    end
    if (unit < heap_end_u) begin
      old = 32'(hdr_mem[unit][11:1]);
      if (old >= need + 2) begin
        store_hdr(unit, need, 1'b1);
        store_hdr(unit + need, old - need, 1'b0);
      end else begin
        store_hdr(unit, old, 1'b1);
      end
    end else begin
      eff = (limit_u > HeapUnits) ? HeapUnits : limit_u;
      if (heap_end_u + need > eff) return 1'b1;
      unit = heap_end_u;
      heap_end_u += need;
      store_hdr(unit, need, 1'b1);
    end
    res.payload_offset = OffW'((unit + 1) * 16);
    res.granted = 1'b1;
    return 1'b1;
  endfunction

  // Mostly allocations and frees of live block starts; some null and bad offsets.
  function automatic in_item_t next_random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned sel;
    int unsigned unit;
    it.kind = KindAlloc;
    it.request_size = ReqW'($urandom);
    it.release_offset = OffW'($urandom_range(0, 16384));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) it.request_size = '0;
      else if (sel < 70) it.request_size = ReqW'($urandom_range(1, 120));
      else if (sel < 92) it.request_size = ReqW'($urandom_range(121, 1000));
      else it.request_size = ReqW'($urandom_range(1001, 65535));
    end else begin
      it.kind = KindFree;
      if (pick < 90 && heap_end_u != 0) begin
        unit = $urandom_range(0, heap_end_u - 1);
        while (!hdr_written[unit]) unit--;
        it.release_offset = OffW'((unit + 1) * 16);
      end else if (pick < 93) begin
        it.release_offset = '0;
      end else if (it.release_offset != '0 && it.release_offset[3:0] == 4'd0) begin
        // never touch a header that was not written yet
        unit = 32'(it.release_offset) / 16 - 1;
        if (unit < heap_end_u && !hdr_written[unit]) it.release_offset = '0;
      end
    end
    return it;
  endfunction

  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    bit        has_res;
    bit        counted;
    if (!steady && $urandom_range(0, 99) < 14) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    has_res = alloc_outcome(it, res, counted);
    if (counted) useful_items++;
    if (has_res) result_q.push_back(typed ? want : res);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    // a trailing free has no result; give it time to retire
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_heap_limit(input logic [LimitW-1:0] lim);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_u = lim;
    limits_set++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result sink: random stalls, one long hold-off once traffic is flowing
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = 299;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (result_q.size() == 0) begin
        $error("unexpected item: payload_offset %0d granted %0d",
               out_data_o.payload_offset, out_data_o.granted);
        n_errors++;
      end else begin
        want = result_q.pop_front();
        if (out_data_o.granted) grants_seen++;
        if (out_data_o.payload_offset !== want.payload_offset) begin
          $error("payload_offset: expected %0d, got %0d",
                 want.payload_offset, out_data_o.payload_offset);
          n_errors++;
        end
        if (out_data_o.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, out_data_o.granted);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[first_fit_block_allocator] ERROR");
    $finish;
  end

  initial begin
    logic [LimitW-1:0] phase_lim [5];
    int unsigned       start;
    bit                paused;
    phase_lim[0] = LimitW'($urandom_range(200, 400));
    phase_lim[1] = '0;
    phase_lim[2] = '1;
    phase_lim[3] = LimitW'($urandom_range(0, 2047));
    phase_lim[4] = LimitReset;
    paused = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      set_heap_limit(phase_lim[ph]);
      start = useful_items;
      while (useful_items - start < PhaseItems) begin
        steady = (ph == 3) && (useful_items - start < 120);
        if (ph == 2 && !paused && useful_items - start >= 95) begin
          paused = 1'b1;
          drain_results();
        end
        offer_item(next_random_item(), 1'b0, '0);
      end
      steady = 1'b0;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);

    $display("covered %0d allocate/free items over %0d heap limit settings",
             useful_items, limits_set);
    $display("checked %0d results, %0d granted; heap grew to %0d units",
             results_seen, grants_seen, heap_end_u);
    if (n_errors == 0) begin
      $display("[first_fit_block_allocator] OK");
    end else begin
      $display("[first_fit_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
